// ===== hw/rtl/fsg_pkg.sv =====
// Shared types and constants of the finite-difference stencil entry generator.
package fsg_pkg;

   localparam int NODE_W = 18;
   localparam int IDX_W = 20;
   localparam int VAL_W = 13;
   localparam int SIDE_W = 7;
   localparam int DIM_W = 2;
   localparam int SPC_W = 3;
   localparam int NDIM = 3;
   localparam int CSR_AW = 4;
   localparam int CSR_DW = 32;

   // Upper limits that the species count and the mesh side are clamped to.
   localparam int MAX_SPECIES = 4;
   localparam int MAX_SIDE = 64;

   // The divider retires two quotient bits per cycle.
   localparam int DIV_STEPS = NODE_W / 2;
   localparam int CNT_W = $clog2(DIV_STEPS);

   localparam int QDEPTH = 2;
   localparam int QAW = $clog2(QDEPTH);

   localparam logic [1:0] REG_NODES = 2'd0;
   localparam logic [1:0] REG_DIMS = 2'd1;
   localparam logic [1:0] REG_SPECIES = 2'd2;

   typedef struct packed {
      logic [SIDE_W-1:0] n;
      logic [DIM_W-1:0]  dims;
      logic [SPC_W-1:0]  sp;
   } cfg_type;

   typedef struct packed {
      logic              bad;
      logic [IDX_W-1:0]  node_sp;
      logic [IDX_W-1:0]  ssp1;
      logic [IDX_W-1:0]  ssp2;
      logic [NDIM-1:0]   lo;
      logic [NDIM-1:0]   hi;
      logic [VAL_W-1:0]  coeff;
   } entry_type;

endpackage

// ===== hw/rtl/fdm_stencil_triplet_generator_top.sv =====
// Top level of the finite-difference Laplacian stencil entry generator.
// Throughput: the front end works through one request at a time with a shared divider
// that retires two quotient bits per cycle, while one further request waits in its buffer;
// the back end emits one entry per cycle whenever the result side is not stalling.
// Reset is synchronous and active high; it empties the pipeline and restores n=2,
// one dimension and one species. There is no clearing pass.
module fdm_stencil_triplet_generator_top import fsg_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   // Request channel: one mesh node index per request.
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [NODE_W-1:0]        req_node_index,
   // Result channel: one sparse-matrix entry per transfer.
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [IDX_W-1:0]         rsp_row,
   output logic [IDX_W-1:0]         rsp_column,
   output logic signed [VAL_W-1:0]  rsp_value,
   output logic                     rsp_bad_node,
   output logic                     rsp_last,
   // Configuration port.
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_AW-1:0]        csr_paddr,
   input  logic [CSR_DW-1:0]        csr_pwdata,
   output logic [CSR_DW-1:0]        csr_prdata,
   output logic                     csr_pready
);

   // The registers keep the bits exactly as written; the clamping to legal
   // ranges is applied only where the values are used.
   logic [SIDE_W-1:0] nodes_ff;
   logic [DIM_W-1:0]  dims_ff;
   logic [SPC_W-1:0]  species_ff;
   logic              csr_write;
   cfg_type           cfg;

   logic              ent_valid;
   logic              ent_ready;
   entry_type         ent;
   logic              head_valid;
   logic              head_ready;
   entry_type         head;

   assign csr_pready = 1'b1;
   assign csr_write = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         nodes_ff <= SIDE_W'(2);
         dims_ff <= DIM_W'(1);
         species_ff <= SPC_W'(1);
      end else if (csr_write) begin
         case (csr_paddr[3:2])
            REG_NODES: nodes_ff <= csr_pwdata[SIDE_W-1:0];
            REG_DIMS: dims_ff <= csr_pwdata[DIM_W-1:0];
            REG_SPECIES: species_ff <= csr_pwdata[SPC_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         REG_NODES: csr_prdata = {{(CSR_DW-SIDE_W){1'b0}}, nodes_ff};
         REG_DIMS: csr_prdata = {{(CSR_DW-DIM_W){1'b0}}, dims_ff};
         REG_SPECIES: csr_prdata = {{(CSR_DW-SPC_W){1'b0}}, species_ff};
         default: csr_prdata = '0;
      endcase
   end

   // Effective configuration seen by both ends of the pipeline.
   always_comb begin
      if (nodes_ff < SIDE_W'(2)) begin
         cfg.n = SIDE_W'(2);
      end else if (int'(nodes_ff) > MAX_SIDE) begin
         cfg.n = SIDE_W'(MAX_SIDE);
      end else begin
         cfg.n = nodes_ff;
      end

      if (dims_ff == '0) begin
         cfg.dims = DIM_W'(1);
      end else begin
         cfg.dims = dims_ff;
      end

      if (species_ff == '0) begin
         cfg.sp = SPC_W'(1);
      end else if (int'(species_ff) > MAX_SPECIES) begin
         cfg.sp = SPC_W'(MAX_SPECIES);
      end else begin
         cfg.sp = species_ff;
      end
   end

   // The front end splits the node index into coordinates and marks the
   // boundaries; it buffers one further request while it works.
   fsg_front u_front (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_node_index (req_node_index),
      .ent_valid      (ent_valid),
      .ent_ready      (ent_ready),
      .ent            (ent)
   );

   // The queue lets the front end start on the next request while the back
   // end is still emitting entries of the previous one.
   fsg_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (ent_valid),
      .push_ready (ent_ready),
      .push_entry (ent),
      .pop_valid  (head_valid),
      .pop_ready  (head_ready),
      .pop_entry  (head)
   );

   // The back end walks the diagonal block and then the neighbour entries,
   // one entry per cycle while the output is not stalled, into a registered output stage.
   fsg_back u_back (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg),
      .ent_valid    (head_valid),
      .ent_ready    (head_ready),
      .ent          (head),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_row      (rsp_row),
      .rsp_column   (rsp_column),
      .rsp_value    (rsp_value),
      .rsp_bad_node (rsp_bad_node),
      .rsp_last     (rsp_last)
   );

endmodule

// ===== hw/rtl/fsg_front.sv =====
// Front end: takes a node index, splits it into mesh coordinates and classifies it.
module fsg_front import fsg_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  cfg_type              cfg,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [NODE_W-1:0]    req_node_index,
   output logic                 ent_valid,
   input  logic                 ent_ready,
   output entry_type            ent
);

   localparam logic [2:0] F_IDLE = 3'd0;
   localparam logic [2:0] F_DIV1 = 3'd1;
   localparam logic [2:0] F_DIV2 = 3'd2;
   localparam logic [2:0] F_CALC = 3'd3;
   localparam logic [2:0] F_PUSH = 3'd4;

   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_STEPS - 1);

   logic [2:0]          state_ff, state_in;
   logic                in_valid_ff, in_valid_in;
   logic [NODE_W-1:0]   in_node_ff;
   logic [NODE_W-1:0]   dvd_ff, dvd_in;
   logic [SIDE_W-1:0]   rem_ff, rem_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [2*SIDE_W-1:0] nm1sq_ff, nm1sq_in;
   logic [2*SIDE_W-1:0] nn_ff, nn_in;
   logic [SIDE_W+SPC_W-1:0] nsp_ff, nsp_in;
   logic [2*SIDE_W+SPC_W-1:0] nnsp_ff, nnsp_in;
   logic [NODE_W+SPC_W-1:0] node_sp_ff, node_sp_in;
   logic [SIDE_W-1:0]   x_ff, x_in;
   logic [SIDE_W-1:0]   y_ff, y_in;
   logic [NODE_W-1:0]   q1_ff, q1_in;
   logic [NODE_W-1:0]   q2_ff, q2_in;
   entry_type           ent_ff, ent_in;

   logic [SIDE_W:0]     st1, st2;
   logic [NODE_W-1:0]   dvd_step;
   logic [SIDE_W-1:0]   n_m1;
   logic [2*SIDE_W-1:0] neg_sq;
   logic                bad;

   // One restoring division step: quotient bit on top, new remainder below.
   function automatic logic [SIDE_W:0] div_step(input logic [SIDE_W-1:0] r,
                                                input logic b,
                                                input logic [SIDE_W-1:0] d);
      logic [SIDE_W:0] t;
      logic [SIDE_W:0] s;
      begin
         t = {r, b};
         s = t - {1'b0, d};
         if (t >= {1'b0, d}) begin
            div_step = {1'b1, s[SIDE_W-1:0]};
         end else begin
            div_step = {1'b0, t[SIDE_W-1:0]};
         end
      end
   endfunction

   assign req_ready = !in_valid_ff;
   assign ent_valid = (state_ff == F_PUSH);
   assign ent = ent_ff;

   always_comb begin
      st1 = div_step(rem_ff, dvd_ff[NODE_W-1], cfg.n);
      st2 = div_step(st1[SIDE_W-1:0], dvd_ff[NODE_W-2], cfg.n);
      dvd_step = {dvd_ff[NODE_W-3:0], st1[SIDE_W], st2[SIDE_W]};
      n_m1 = cfg.n - SIDE_W'(1);
      neg_sq = (2*SIDE_W)'(0) - nm1sq_ff;

      case (cfg.dims)
         2'd1: bad = (q1_ff != '0);
         2'd2: bad = (q2_ff != '0);
         default: bad = (q2_ff >= {{(NODE_W-SIDE_W){1'b0}}, cfg.n});
      endcase

      state_in = state_ff;
      in_valid_in = in_valid_ff;
      dvd_in = dvd_ff;
      rem_in = rem_ff;
      cnt_in = cnt_ff;
      nm1sq_in = nm1sq_ff;
      nn_in = nn_ff;
      nsp_in = nsp_ff;
      nnsp_in = nnsp_ff;
      node_sp_in = node_sp_ff;
      x_in = x_ff;
      y_in = y_ff;
      q1_in = q1_ff;
      q2_in = q2_ff;
      ent_in = ent_ff;

      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end

      case (state_ff)
         F_IDLE: begin
            if (in_valid_ff) begin
               in_valid_in = 1'b0;
               dvd_in = in_node_ff;
               rem_in = '0;
               cnt_in = '0;
               nm1sq_in = {{SIDE_W{1'b0}}, n_m1} * {{SIDE_W{1'b0}}, n_m1};
               nn_in = {{SIDE_W{1'b0}}, cfg.n} * {{SIDE_W{1'b0}}, cfg.n};
               nsp_in = {{SPC_W{1'b0}}, cfg.n} * {{SIDE_W{1'b0}}, cfg.sp};
               node_sp_in = {{SPC_W{1'b0}}, in_node_ff} * {{NODE_W{1'b0}}, cfg.sp};
               state_in = F_DIV1;
            end
         end
         F_DIV1: begin
            nnsp_in = {{SPC_W{1'b0}}, nn_ff} * {{(2*SIDE_W){1'b0}}, cfg.sp};
            dvd_in = dvd_step;
            rem_in = st2[SIDE_W-1:0];
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_LAST) begin
               x_in = st2[SIDE_W-1:0];
               q1_in = dvd_step;
               rem_in = '0;
               cnt_in = '0;
               state_in = F_DIV2;
            end
         end
         F_DIV2: begin
            dvd_in = dvd_step;
            rem_in = st2[SIDE_W-1:0];
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_LAST) begin
               y_in = st2[SIDE_W-1:0];
               q2_in = dvd_step;
               state_in = F_CALC;
            end
         end
         F_CALC: begin
            ent_in.bad = bad;
            ent_in.node_sp = node_sp_ff[IDX_W-1:0];
            ent_in.ssp1 = {{(IDX_W-SIDE_W-SPC_W){1'b0}}, nsp_ff};
            ent_in.ssp2 = {{(IDX_W-2*SIDE_W-SPC_W){1'b0}}, nnsp_ff};
            ent_in.lo = {q2_ff[SIDE_W-1:0] == '0, y_ff == '0, x_ff == '0};
            ent_in.hi = {q2_ff[SIDE_W-1:0] == n_m1, y_ff == n_m1, x_ff == n_m1};
            ent_in.coeff = neg_sq[VAL_W-1:0];
            state_in = F_PUSH;
         end
         F_PUSH: begin
            if (ent_ready) begin
               state_in = F_IDLE;
            end
         end
         default: begin
            state_in = F_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         in_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_node_ff <= req_node_index;
      end
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
      nm1sq_ff <= nm1sq_in;
      nn_ff <= nn_in;
      nsp_ff <= nsp_in;
      nnsp_ff <= nnsp_in;
      node_sp_ff <= node_sp_in;
      x_ff <= x_in;
      y_ff <= y_in;
      q1_ff <= q1_in;
      q2_ff <= q2_in;
      ent_ff <= ent_in;
   end

endmodule

// ===== hw/rtl/fsg_queue.sv =====
// Short queue of classified node descriptors between the front and back ends.
module fsg_queue import fsg_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      push_valid,
   output logic      push_ready,
   input  entry_type push_entry,
   output logic      pop_valid,
   input  logic      pop_ready,
   output entry_type pop_entry
);

   entry_type        mem_ff [QDEPTH];
   logic [QAW-1:0]   wr_ptr_ff;
   logic [QAW-1:0]   rd_ptr_ff;
   logic [QAW:0]     count_ff;
   logic             do_push;
   logic             do_pop;

   assign push_ready = (count_ff != (QAW+1)'(QDEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_entry = mem_ff[rd_ptr_ff];
   assign do_push = push_valid && push_ready;
   assign do_pop = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + QAW'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + QAW'(1);
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + (QAW+1)'(1);
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - (QAW+1)'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ===== hw/rtl/fsg_back.sv =====
// Back end: walks one node descriptor and emits its matrix entries one per cycle when not stalled.
module fsg_back import fsg_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  cfg_type                  cfg,
   input  logic                     ent_valid,
   output logic                     ent_ready,
   input  entry_type                ent,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [IDX_W-1:0]         rsp_row,
   output logic [IDX_W-1:0]         rsp_column,
   output logic signed [VAL_W-1:0]  rsp_value,
   output logic                     rsp_bad_node,
   output logic                     rsp_last
);

   localparam logic B_DIAG = 1'b0;
   localparam logic B_NEIGH = 1'b1;

   logic                phase_ff, phase_in;
   logic [SPC_W-1:0]    s1_ff, s1_in;
   logic [SPC_W-1:0]    s2_ff, s2_in;
   logic [DIM_W-1:0]    d_ff, d_in;
   logic                side_ff, side_in;
   logic                valid_ff;
   logic [IDX_W-1:0]    row_ff, row_in;
   logic [IDX_W-1:0]    col_ff, col_in;
   logic [VAL_W-1:0]    val_ff, val_in;
   logic                bad_ff, bad_in;
   logic                last_ff, last_in;

   logic                load;
   logic [IDX_W-1:0]    stride;
   logic                lo_sel;
   logic                hi_sel;
   logic                plus;
   logic [IDX_W-1:0]    nb_sp;
   logic [SPC_W-1:0]    sp_m1;
   logic [DIM_W-1:0]    d_last;

   assign load = ent_valid && (!valid_ff || rsp_ready);
   assign ent_ready = load && last_in;

   assign rsp_valid = valid_ff;
   assign rsp_row = row_ff;
   assign rsp_column = col_ff;
   assign rsp_value = val_ff;
   assign rsp_bad_node = bad_ff;
   assign rsp_last = last_ff;

   always_comb begin
      sp_m1 = cfg.sp - SPC_W'(1);
      d_last = cfg.dims - DIM_W'(1);

      case (d_ff)
         2'd0: begin
            stride = {{(IDX_W-SPC_W){1'b0}}, cfg.sp};
            lo_sel = ent.lo[0];
            hi_sel = ent.hi[0];
         end
         2'd1: begin
            stride = ent.ssp1;
            lo_sel = ent.lo[1];
            hi_sel = ent.hi[1];
         end
         default: begin
            stride = ent.ssp2;
            lo_sel = ent.lo[2];
            hi_sel = ent.hi[2];
         end
      endcase

      // A missing neighbour at the boundary is mirrored to the opposite side.
      plus = side_ff ? !hi_sel : lo_sel;
      nb_sp = plus ? (ent.node_sp + stride) : (ent.node_sp - stride);

      phase_in = phase_ff;
      s1_in = s1_ff;
      s2_in = s2_ff;
      d_in = d_ff;
      side_in = side_ff;
      row_in = ent.node_sp + {{(IDX_W-SPC_W){1'b0}}, s1_ff};
      col_in = '0;
      val_in = '0;
      bad_in = 1'b0;
      last_in = 1'b0;

      if (ent.bad) begin
         row_in = '0;
         bad_in = 1'b1;
         last_in = 1'b1;
      end else if (phase_ff == B_DIAG) begin
         col_in = ent.node_sp + {{(IDX_W-SPC_W){1'b0}}, s2_ff};
         if (s2_ff == sp_m1) begin
            s2_in = '0;
            if (s1_ff == sp_m1) begin
               s1_in = '0;
               phase_in = B_NEIGH;
            end else begin
               s1_in = s1_ff + SPC_W'(1);
            end
         end else begin
            s2_in = s2_ff + SPC_W'(1);
         end
      end else begin
         col_in = nb_sp + {{(IDX_W-SPC_W){1'b0}}, s1_ff};
         val_in = ent.coeff;
         last_in = (d_ff == d_last) && side_ff && (s1_ff == sp_m1);
         if (s1_ff == sp_m1) begin
            s1_in = '0;
            if (side_ff) begin
               side_in = 1'b0;
               d_in = d_ff + DIM_W'(1);
            end else begin
               side_in = 1'b1;
            end
         end else begin
            s1_in = s1_ff + SPC_W'(1);
         end
      end

      if (last_in) begin
         phase_in = B_DIAG;
         s1_in = '0;
         s2_in = '0;
         d_in = '0;
         side_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= B_DIAG;
         s1_ff <= '0;
         s2_ff <= '0;
         d_ff <= '0;
         side_ff <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         if (load) begin
            phase_ff <= phase_in;
            s1_ff <= s1_in;
            s2_ff <= s2_in;
            d_ff <= d_in;
            side_ff <= side_in;
            valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         row_ff <= row_in;
         col_ff <= col_in;
         val_ff <= val_in;
         bad_ff <= bad_in;
         last_ff <= last_in;
      end
   end

endmodule

// ===== hw/rtl/fsg_checker.sv =====
// Port-level checks for the stencil entry generator, bound to its top level.
module fsg_checker import fsg_pkg::*; (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_ready,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input logic [IDX_W-1:0]         rsp_row,
   input logic [IDX_W-1:0]         rsp_column,
   input logic signed [VAL_W-1:0]  rsp_value,
   input logic                     rsp_bad_node,
   input logic                     rsp_last
);

   // A stalled result keeps its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_row) && $stable(rsp_column)
         && $stable(rsp_value) && $stable(rsp_bad_node) && $stable(rsp_last))
      else $error("result changed while stalled");

   // An out-of-mesh node yields a single, all-zero, final entry.
   a_bad_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_bad_node |-> rsp_last && rsp_row == '0 && rsp_column == '0
         && rsp_value == '0)
      else $error("bad node entry malformed");

   // Reset empties the output stage.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // The single input buffer is full right after a request is taken.
   a_req_buffer: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request buffer accepted twice");

endmodule

bind fdm_stencil_triplet_generator_top fsg_checker u_fsg_checker (.*);

// ===== verif/tb_fdm_stencil_triplet_generator_top.sv =====
// Self-checking testbench for the finite-difference Laplacian stencil entry generator.
`timescale 1ns / 1ps

module tb_fdm_stencil_triplet_generator_top;
   import fsg_pkg::*;

   localparam int SIDE_LIMIT = MAX_SIDE;
   localparam int SPECIES_LIMIT = MAX_SPECIES;
   localparam int NODE_SPAN = 1 << NODE_W;
   localparam int PHASES = 8;
   localparam int PHASE_REQUESTS = 45;
   localparam int IDLE_PERCENT = 34;

   // Register byte addresses: register i sits at 4*i.
   localparam logic [CSR_AW-1:0] ADDR_NODES = {REG_NODES, 2'b00};
   localparam logic [CSR_AW-1:0] ADDR_DIMS = {REG_DIMS, 2'b00};
   localparam logic [CSR_AW-1:0] ADDR_SPECIES = {REG_SPECIES, 2'b00};
   // The fourth slot holds no register, so a write there must change nothing.
   localparam logic [CSR_AW-1:0] ADDR_SPARE = {2'd3, 2'b00};

   typedef struct packed {
      logic [IDX_W-1:0]        row;
      logic [IDX_W-1:0]        column;
      logic signed [VAL_W-1:0] value;
      logic                    bad_node;
      logic                    last;
   } stencil_entry_type;

   // A directed row either writes a register, sends a node whose entries come from
   // the predictor, or sends a node outside the mesh whose single entry is typed in.
   typedef enum logic [1:0] {ROW_NODE, ROW_OUTSIDE, ROW_WRITE} plan_kind_type;

   typedef struct packed {
      plan_kind_type     kind;
      logic [CSR_AW-1:0] addr;
      logic [31:0]       data;
   } plan_row_type;

   localparam stencil_entry_type OUTSIDE_ENTRY = '{'0, '0, '0, 1'b1, 1'b1};

   localparam plan_row_type DIRECTED_PLAN [34] = '{
      // Straight after reset: n = 2, one dimension, one species.
      '{ROW_NODE,    '0,           32'd0},
      '{ROW_NODE,    '0,           32'd1},
      '{ROW_OUTSIDE, '0,           32'd2},
      '{ROW_OUTSIDE, '0,           32'd262143},
      // Largest mesh: both corners and an interior node, forty entries each.
      '{ROW_WRITE,   ADDR_NODES,   32'd64},
      '{ROW_WRITE,   ADDR_DIMS,    32'd3},
      '{ROW_WRITE,   ADDR_SPECIES, 32'd4},
      '{ROW_NODE,    '0,           32'd0},
      '{ROW_NODE,    '0,           32'd262143},
      '{ROW_NODE,    '0,           32'd133151},
      // Zero in every register clamps up to the smallest mesh.
      '{ROW_WRITE,   ADDR_NODES,   32'd0},
      '{ROW_WRITE,   ADDR_DIMS,    32'd0},
      '{ROW_WRITE,   ADDR_SPECIES, 32'd0},
      '{ROW_NODE,    '0,           32'd1},
      '{ROW_OUTSIDE, '0,           32'd2},
      // Oversized side and species count clamp down to their limits.
      '{ROW_WRITE,   ADDR_NODES,   32'd127},
      '{ROW_WRITE,   ADDR_DIMS,    32'd2},
      '{ROW_WRITE,   ADDR_SPECIES, 32'd7},
      '{ROW_NODE,    '0,           32'd4095},
      '{ROW_OUTSIDE, '0,           32'd4096},
      '{ROW_NODE,    '0,           32'd65},
      '{ROW_NODE,    '0,           32'd4032},
      // Small cube, with a write to the empty slot in between.
      '{ROW_WRITE,   ADDR_NODES,   32'd3},
      '{ROW_WRITE,   ADDR_DIMS,    32'd3},
      '{ROW_WRITE,   ADDR_SPECIES, 32'd5},
      '{ROW_WRITE,   ADDR_SPARE,   32'hFFFF_FFFF},
      '{ROW_NODE,    '0,           32'd13},
      '{ROW_NODE,    '0,           32'd26},
      '{ROW_OUTSIDE, '0,           32'd27},
      // Junk in the upper data bits is dropped; only the register's own bits count.
      '{ROW_WRITE,   ADDR_NODES,   32'hFFFF_FF81},
      '{ROW_WRITE,   ADDR_DIMS,    32'hFFFF_FFFE},
      '{ROW_WRITE,   ADDR_SPECIES, 32'hFFFF_FFFA},
      '{ROW_NODE,    '0,           32'd3},
      '{ROW_OUTSIDE, '0,           32'd4}
   };

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_ready;
   logic [NODE_W-1:0]       req_node_index = '0;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   logic [IDX_W-1:0]        rsp_row;
   logic [IDX_W-1:0]        rsp_column;
   logic signed [VAL_W-1:0] rsp_value;
   logic                    rsp_bad_node;
   logic                    rsp_last;
   logic                    csr_psel = 1'b0;
   logic                    csr_penable = 1'b0;
   logic                    csr_pwrite = 1'b0;
   logic [CSR_AW-1:0]       csr_paddr = '0;
   logic [CSR_DW-1:0]       csr_pwdata = '0;
   logic [CSR_DW-1:0]       csr_prdata;
   logic                    csr_pready;

   // When set, neither side idles: this gives the long stretch at full rate.
   logic                    calm = 1'b0;

   // Our own copy of the registers, holding the raw written bits.
   logic [SIDE_W-1:0]       shadow_side = SIDE_W'(2);
   logic [DIM_W-1:0]        shadow_dims = DIM_W'(1);
   logic [SPC_W-1:0]        shadow_species = SPC_W'(1);

   stencil_entry_type       stencil_entries_due[$];
   int                      bad_checks = 0;

   fdm_stencil_triplet_generator_top dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_node_index(req_node_index),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_row(rsp_row),
      .rsp_column(rsp_column),
      .rsp_value(rsp_value),
      .rsp_bad_node(rsp_bad_node),
      .rsp_last(rsp_last),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always #10 clock = ~clock;

   // Hard stop well beyond the slowest legal run.
   initial begin
      #10_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   task automatic log_failure(input string text);
      bad_checks++;
      if (bad_checks <= 10) begin
         $display("%s", text);
      end
   endtask

   // Appends one entry to the tail of the list of entries still due.
   task automatic add_due(input stencil_entry_type e);
      stencil_entries_due.insert(stencil_entries_due.size(), e);
   endtask

   function automatic int clamp_to(input int v, input int lo, input int hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

   // Number of nodes in the mesh under the current register settings.
   function automatic int mesh_nodes();
      int side;
      int dims;
      int total;
      side = clamp_to(int'(shadow_side), 2, SIDE_LIMIT);
      dims = clamp_to(int'(shadow_dims), 1, NDIM);
      total = 1;
      for (int d = 0; d < dims; d++) total *= side;
      return total;
   endfunction

   // Works out every entry that one accepted request should produce and queues them.
   // The diagonal block comes first, then for each axis the left neighbours of all
   // species followed by the right neighbours; a neighbour off the mesh edge is
   // mirrored onto the opposite one.
   task automatic predict_stencil(input logic [NODE_W-1:0] node_bits);
      int node;
      int side;
      int dims;
      int spc;
      int stride;
      int pos;
      int left;
      int right;
      int count;
      int k;
      logic signed [VAL_W-1:0] weight;
      node = int'(node_bits);
      side = clamp_to(int'(shadow_side), 2, SIDE_LIMIT);
      dims = clamp_to(int'(shadow_dims), 1, NDIM);
      spc = clamp_to(int'(shadow_species), 1, SPECIES_LIMIT);
      if (node >= mesh_nodes()) begin
         add_due(OUTSIDE_ENTRY);
         return;
      end
      weight = VAL_W'(-((side - 1) * (side - 1)));
      count = spc * spc + 2 * dims * spc;
      k = 0;
      for (int s1 = 0; s1 < spc; s1++) begin
         for (int s2 = 0; s2 < spc; s2++) begin
            add_due('{IDX_W'(node * spc + s1), IDX_W'(node * spc + s2),
                      '0, 1'b0, k == count - 1});
            k++;
         end
      end
      stride = 1;
      for (int d = 0; d < dims; d++) begin
         pos = (node / stride) % side;
         left = node - stride;
         right = node + stride;
         if (pos == 0) left = right;
         else if (pos == side - 1) right = left;
         for (int s = 0; s < spc; s++) begin
            add_due('{IDX_W'(node * spc + s), IDX_W'(left * spc + s),
                      weight, 1'b0, k == count - 1});
            k++;
         end
         for (int s = 0; s < spc; s++) begin
            add_due('{IDX_W'(node * spc + s), IDX_W'(right * spc + s),
                      weight, 1'b0, k == count - 1});
            k++;
         end
         stride *= side;
      end
   endtask

   // Random node: mostly inside the mesh with coordinates pushed towards the edges,
   // sometimes beyond the last node.
   function automatic logic [NODE_W-1:0] random_node();
      int side;
      int dims;
      int total;
      int stride;
      int node;
      int c;
      side = clamp_to(int'(shadow_side), 2, SIDE_LIMIT);
      dims = clamp_to(int'(shadow_dims), 1, NDIM);
      total = mesh_nodes();
      if (total < NODE_SPAN && $urandom_range(0, 99) < 12) begin
         return NODE_W'($urandom_range(total, NODE_SPAN - 1));
      end
      node = 0;
      stride = 1;
      for (int d = 0; d < dims; d++) begin
         if ($urandom_range(0, 99) < 30) c = $urandom_range(0, 1) ? side - 1 : 0;
         else c = $urandom_range(0, side - 1);
         node += c * stride;
         stride *= side;
      end
      return NODE_W'(node);
   endfunction

   // Offers one request, idling first at random, and holds it until it is taken.
   // Valid is only lowered during an idle gap, never in the step that raises it.
   task automatic send_node(input logic [NODE_W-1:0] node, input logic typed_outside);
      if (!calm) begin
         while ($urandom_range(0, 99) < IDLE_PERCENT) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid <= 1'b1;
      req_node_index <= node;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (typed_outside) add_due(OUTSIDE_ENTRY);
      else predict_stencil(node);
   endtask

   // Stops offering requests and waits until every queued entry has arrived.
   task automatic drain();
      req_valid <= 1'b0;
      wait (stencil_entries_due.size() == 0);
      @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // One register write, followed by a read of the same register to check it.
   task automatic csr_write(input logic [CSR_AW-1:0] addr, input logic [CSR_DW-1:0] data);
      logic [CSR_DW-1:0] held;
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= addr;
      csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      case (addr)
         ADDR_NODES:   shadow_side = data[SIDE_W-1:0];
         ADDR_DIMS:    shadow_dims = data[DIM_W-1:0];
         ADDR_SPECIES: shadow_species = data[SPC_W-1:0];
         default:      ;
      endcase
      case (addr)
         ADDR_NODES:   held = CSR_DW'(shadow_side);
         ADDR_DIMS:    held = CSR_DW'(shadow_dims);
         ADDR_SPECIES: held = CSR_DW'(shadow_species);
         default:      held = '0;
      endcase
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (addr != ADDR_SPARE && csr_prdata !== held) begin
         log_failure($sformatf("register at %0d reads %0h, expected %0h", addr, csr_prdata,
                               held));
      end
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      // The port goes quiet before anything else is driven.
      @(posedge clock);
   endtask

   // The result side stalls at random, except during the calm stretch.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= calm || ($urandom_range(0, 99) >= IDLE_PERCENT);
      end
   end

   // Every entry taken is compared with the oldest one still due.
   always @(posedge clock) begin : entry_check
      stencil_entry_type want;
      stencil_entry_type seen;
      if (!reset && rsp_valid && rsp_ready) begin
         seen = '{rsp_row, rsp_column, rsp_value, rsp_bad_node, rsp_last};
         if (stencil_entries_due.size() == 0) begin
            log_failure($sformatf("unexpected entry row %0d column %0d value %0d bad %0b last %0b",
                                  seen.row, seen.column, seen.value, seen.bad_node, seen.last));
         end else begin
            want = stencil_entries_due.pop_front();
            if (seen.row !== want.row || seen.column !== want.column ||
                seen.value !== want.value || seen.bad_node !== want.bad_node ||
                seen.last !== want.last) begin
               log_failure($sformatf(
                  "entry mismatch: expected %0d/%0d/%0d/%0b/%0b, got %0d/%0d/%0d/%0b/%0b",
                  want.row, want.column, want.value, want.bad_node, want.last,
                  seen.row, seen.column, seen.value, seen.bad_node, seen.last));
            end
         end
      end
   end

   initial begin : stimulus
      logic [SIDE_W-1:0] side_pick;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part: registers are only touched once the block has gone quiet.
      foreach (DIRECTED_PLAN[i]) begin
         case (DIRECTED_PLAN[i].kind)
            ROW_WRITE: begin
               drain();
               csr_write(DIRECTED_PLAN[i].addr, DIRECTED_PLAN[i].data);
            end
            ROW_OUTSIDE: send_node(DIRECTED_PLAN[i].data[NODE_W-1:0], 1'b1);
            default: send_node(DIRECTED_PLAN[i].data[NODE_W-1:0], 1'b0);
         endcase
      end

      // Random part: a fresh configuration per phase. The first phases pin the
      // largest mesh (run without any idling) and the thinnest ones.
      for (int phase = 0; phase < PHASES; phase++) begin
         drain();
         calm <= (phase == 0);
         case (phase)
            0: begin
               csr_write(ADDR_NODES, CSR_DW'(SIDE_LIMIT));
               csr_write(ADDR_DIMS, CSR_DW'(NDIM));
               csr_write(ADDR_SPECIES, CSR_DW'(SPECIES_LIMIT));
            end
            1: begin
               csr_write(ADDR_NODES, CSR_DW'(2));
               csr_write(ADDR_DIMS, CSR_DW'(NDIM));
               csr_write(ADDR_SPECIES, CSR_DW'(1));
            end
            2: begin
               csr_write(ADDR_NODES, CSR_DW'(2));
               csr_write(ADDR_DIMS, CSR_DW'(1));
               csr_write(ADDR_SPECIES, CSR_DW'(SPECIES_LIMIT));
            end
            default: begin
               case ($urandom_range(0, 7))
                  0: side_pick = SIDE_W'(0);
                  1: side_pick = SIDE_W'(1);
                  2: side_pick = SIDE_W'(SIDE_LIMIT);
                  3: side_pick = SIDE_W'($urandom_range(SIDE_LIMIT + 1, 127));
                  default: side_pick = SIDE_W'($urandom_range(2, SIDE_LIMIT));
               endcase
               // Random upper data bits show that only the register's own bits stick.
               csr_write(ADDR_NODES, ($urandom() & ~CSR_DW'(127)) | CSR_DW'(side_pick));
               csr_write(ADDR_DIMS, ($urandom() & ~CSR_DW'(3)) | CSR_DW'($urandom_range(0, 3)));
               csr_write(ADDR_SPECIES, ($urandom() & ~CSR_DW'(7)) |
                                       CSR_DW'($urandom_range(0, 7)));
            end
         endcase
         for (int i = 0; i < PHASE_REQUESTS; i++) begin
            // Once in the run the sender holds back until every entry has come out.
            if (phase == 3 && i == PHASE_REQUESTS / 2) begin
               req_valid <= 1'b0;
               wait (stencil_entries_due.size() == 0);
               @(posedge clock);
            end
            send_node(random_node(), 1'b0);
         end
      end

      drain();
      calm <= 1'b0;
      repeat (40) @(posedge clock);
      if (bad_checks == 0 && stencil_entries_due.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// ===== fdm_stencil_triplet_generator_top.f =====
hw/rtl/fsg_pkg.sv
hw/rtl/fsg_front.sv
hw/rtl/fsg_queue.sv
hw/rtl/fsg_back.sv
hw/rtl/fdm_stencil_triplet_generator_top.sv
hw/rtl/fsg_checker.sv
verif/tb_fdm_stencil_triplet_generator_top.sv
